// ===== hw/rtl/hufd_pkg.sv =====
// shared types and constants of the huffman tree decoder
`default_nettype none

package hufd_pkg;

  // default sizes of the node table and the build stack
  localparam int MAX_NODES_DEF   = 512;
  localparam int STACK_DEPTH_DEF = 256;

  typedef logic [1:0]  op_t;
  typedef logic [7:0]  sym_t;
  typedef logic [31:0] size_t;

  // operation codes of an input transaction
  localparam op_t OP_TREE  = 2'd0;
  localparam op_t OP_DATA  = 2'd1;
  localparam op_t OP_START = 2'd2;

  // tree token that announces a leaf byte
  localparam sym_t LEAF_TOKEN = 8'd1;

  // first code bit of a data byte
  localparam logic [2:0] BIT_TOP = 3'd7;

  // request from the sequencer to the result buffer
  typedef struct packed {
    logic emit;    // new walk result, held back until the next one or the flush
    logic flush;   // release the held result as the last of its byte
    logic single;  // lone result, last of its transaction
    sym_t sym;
    logic done;
    logic err;
  } res_cmd_t;

  // result buffer status
  typedef struct packed {
    logic out_free;
    logic pend_valid;
  } res_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hufd_in_if.sv =====
// input channel: operation code and data byte
`default_nettype none

interface hufd_in_if import hufd_pkg::*; ();
  logic valid;
  logic ready;
  op_t  op;
  sym_t data;

  modport source (output valid, output op, output data, input ready);
  modport sink (input valid, input op, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hufd_out_if.sv =====
// result channel: decoded symbol and flags
`default_nettype none

interface hufd_out_if import hufd_pkg::*; ();
  logic valid;
  logic ready;
  sym_t symbol;
  logic last_in_run;
  logic stream_done;
  logic error;

  modport source (output valid, output symbol, output last_in_run, output stream_done,
                  output error, input ready);
  modport sink (input valid, input symbol, input last_in_run, input stream_done,
                input error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hufd_cfg_if.sv =====
// configuration write channel: original stream size
`default_nettype none

interface hufd_cfg_if import hufd_pkg::*; ();
  logic  valid;
  logic  ready;
  size_t original_size;

  modport source (output valid, output original_size, input ready);
  modport sink (input valid, input original_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hufd_result_buf.sv =====
// result buffer: one held walk result plus the output register
`default_nettype none

module hufd_result_buf import hufd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_cmd_t  cmd,
  output res_stat_t stat,
  hufd_out_if.source out_if
);

  logic out_valid_r, out_valid_nxt;
  logic pend_valid_r, pend_valid_nxt;
  sym_t out_sym_r, out_sym_nxt;
  logic out_last_r, out_last_nxt;
  logic out_done_r, out_done_nxt;
  logic out_err_r, out_err_nxt;
  sym_t pend_sym_r;
  logic pend_done_r;
  logic load_out;
  logic out_free;

  // output register drains when taken
  assign out_free = !out_valid_r || out_if.ready;

  assign stat.out_free   = out_free;
  assign stat.pend_valid = pend_valid_r;

  // select what enters the output register
  always_comb begin
    load_out     = 1'b0;
    out_sym_nxt  = out_sym_r;
    out_last_nxt = out_last_r;
    out_done_nxt = out_done_r;
    out_err_nxt  = out_err_r;
    priority if (cmd.single) begin
      load_out     = 1'b1;
      out_sym_nxt  = cmd.sym;
      out_last_nxt = 1'b1;
      out_done_nxt = cmd.done;
      out_err_nxt  = cmd.err;
    end else if ((cmd.emit || cmd.flush) && pend_valid_r) begin
      // held result moves out; it is last only on a flush
      load_out     = 1'b1;
      out_sym_nxt  = pend_sym_r;
      out_last_nxt = cmd.flush;
      out_done_nxt = pend_done_r;
      out_err_nxt  = 1'b0;
    end else begin
      load_out = 1'b0;
    end
    out_valid_nxt  = load_out || (out_valid_r && !out_if.ready);
    pend_valid_nxt = cmd.emit ? 1'b1 : (cmd.flush ? 1'b0 : pend_valid_r);
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
    out_err_r  <= out_err_nxt;
    if (cmd.emit) begin
      pend_sym_r  <= cmd.sym;
      pend_done_r <= cmd.done;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.symbol      = out_sym_r;
  assign out_if.last_in_run = out_last_r;
  assign out_if.stream_done = out_done_r;
  assign out_if.error       = out_err_r;

endmodule

`default_nettype wire

// ===== hw/rtl/huffman_tree_decoder_unit.sv =====
// huffman tree decoder: postorder tree rebuild and bit-serial code walk
//
//   channel   direction  handshake          payload
//   in_if     sink       valid/ready        op, data
//   out_if    source     valid/ready        symbol, last_in_run, stream_done, error
//   cfg_if    sink       valid/ready(=1)    original_size
//
// leaf, leaf token and start complete in S_IDLE; a join makes four reads of the
// stack and node table, then the write; an error result goes out from S_ERR.
// a data byte makes one node-table read per code bit, the next address formed
// from the registered read data of the previous bit.
// reset is synchronous; the stores need no clearing pass.
// a full output register and a held result stall the walk; input is taken
// only between transactions, configuration at any time.
`default_nettype none

module huffman_tree_decoder_unit import hufd_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hufd_in_if.sink    in_if,
  hufd_out_if.source out_if,
  hufd_cfg_if.sink   cfg_if
);

  localparam int NIDX_W = $clog2(MAX_NODES);
  localparam int NCNT_W = $clog2(MAX_NODES + 1);
  localparam int SIDX_W = $clog2(STACK_DEPTH);
  localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

  typedef logic [NIDX_W-1:0] nidx_t;
  typedef logic [SIDX_W-1:0] sidx_t;

  typedef struct packed {
    logic  leaf;
    sym_t  sym;
    nidx_t left;
    nidx_t right;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ERR, S_J_LEFT, S_J_SYMR, S_J_SYML, S_J_WRITE, S_WALK, S_FLUSH
  } state_t;

  // stores
  node_t node_mem [MAX_NODES];
  nidx_t stack_mem [STACK_DEPTH];

  state_t            state_r, state_nxt;
  logic [SCNT_W-1:0] stack_count_r, stack_count_nxt;
  logic [NCNT_W-1:0] node_count_r, node_count_nxt;
  logic              expect_leaf_r, expect_leaf_nxt;
  logic              tree_ready_r, tree_ready_nxt;
  size_t             emitted_r, emitted_nxt;
  size_t             orig_size_r;
  nidx_t             root_idx_r, root_idx_nxt;
  nidx_t             walk_idx_r, walk_idx_nxt;
  node_t             root_rec_r, root_rec_nxt;
  node_t             walk_rec_r, walk_rec_nxt;
  nidx_t             cur_idx_r, cur_idx_nxt;
  node_t             cur_rec_r, cur_rec_nxt;
  sym_t              data_r, data_nxt;
  logic [2:0]        bit_r, bit_nxt;
  nidx_t             r_idx_r, r_idx_nxt;
  nidx_t             l_idx_r, l_idx_nxt;
  sym_t              sr_r, sr_nxt;

  // memory ports
  logic  node_we, node_re;
  nidx_t node_waddr, node_raddr;
  node_t node_wdata, node_rd_r;
  logic  stack_we, stack_re;
  sidx_t stack_waddr, stack_raddr;
  nidx_t stack_wdata, stack_rd_r;

  res_cmd_t  cmd;
  res_stat_t stat;

  logic              in_acc;
  logic              node_full, stack_full, stack_short;
  logic              done_now, done_after;
  size_t             emitted_inc;
  logic [SCNT_W-1:0] sc_m1, sc_m2;
  nidx_t             node_new;
  logic              emit_ok;
  logic [2:0]        bit_dec;
  node_t             join_rec;
  sym_t              sl;

  // walk step
  logic  w_emit;
  sym_t  w_sym;
  nidx_t w_child;
  nidx_t w_cur_idx;
  node_t w_cur_rec;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_acc       = in_if.valid && (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign node_full   = node_count_r >= NCNT_W'(MAX_NODES);
  assign stack_full  = stack_count_r >= SCNT_W'(STACK_DEPTH);
  assign stack_short = stack_count_r < SCNT_W'(2);
  assign sc_m1       = stack_count_r - SCNT_W'(1);
  assign sc_m2       = stack_count_r - SCNT_W'(2);
  assign node_new    = node_count_r[NIDX_W-1:0];
  assign emitted_inc = emitted_r + 32'd1;
  assign done_now    = emitted_r >= orig_size_r;
  assign done_after  = emitted_inc >= orig_size_r;
  assign emit_ok     = !stat.pend_valid || stat.out_free;
  assign bit_dec     = bit_r - 3'd1;

  // joined node: smaller first byte goes left, ties take the right operand
  assign sl = node_rd_r.sym;
  always_comb begin
    if (sl < sr_r) begin
      join_rec = '{leaf: 1'b0, sym: sl, left: l_idx_r, right: r_idx_r};
    end else begin
      join_rec = '{leaf: 1'b0, sym: sr_r, left: r_idx_r, right: l_idx_r};
    end
  end

  // one tree step: the read data holds the child chosen by the current bit
  always_comb begin
    w_child = data_r[bit_r] ? cur_rec_r.right : cur_rec_r.left;
    if (root_rec_r.leaf) begin
      w_emit    = 1'b1;
      w_sym     = root_rec_r.sym;
      w_cur_idx = root_idx_r;
      w_cur_rec = root_rec_r;
    end else if (node_rd_r.leaf) begin
      w_emit    = 1'b1;
      w_sym     = node_rd_r.sym;
      w_cur_idx = root_idx_r;
      w_cur_rec = root_rec_r;
    end else begin
      w_emit    = 1'b0;
      w_sym     = node_rd_r.sym;
      w_cur_idx = w_child;
      w_cur_rec = node_rd_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    stack_count_nxt = stack_count_r;
    node_count_nxt  = node_count_r;
    expect_leaf_nxt = expect_leaf_r;
    tree_ready_nxt  = tree_ready_r;
    emitted_nxt     = emitted_r;
    root_idx_nxt    = root_idx_r;
    walk_idx_nxt    = walk_idx_r;
    root_rec_nxt    = root_rec_r;
    walk_rec_nxt    = walk_rec_r;
    cur_idx_nxt     = cur_idx_r;
    cur_rec_nxt     = cur_rec_r;
    data_nxt        = data_r;
    bit_nxt         = bit_r;
    r_idx_nxt       = r_idx_r;
    l_idx_nxt       = l_idx_r;
    sr_nxt          = sr_r;
    node_we         = 1'b0;
    node_waddr      = '0;
    node_wdata      = '0;
    node_re         = 1'b0;
    node_raddr      = '0;
    stack_we        = 1'b0;
    stack_waddr     = '0;
    stack_wdata     = '0;
    stack_re        = 1'b0;
    stack_raddr     = '0;
    cmd             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_if.op)
            OP_START: begin
              stack_count_nxt = '0;
              node_count_nxt  = '0;
              expect_leaf_nxt = 1'b0;
              tree_ready_nxt  = 1'b0;
              emitted_nxt     = '0;
              root_idx_nxt    = '0;
              walk_idx_nxt    = '0;
            end
            OP_TREE: begin
              if (expect_leaf_r) begin
                expect_leaf_nxt = 1'b0;
                if (node_full || stack_full) begin
                  state_nxt = S_ERR;
                end else begin
                  // push a leaf
                  node_we         = 1'b1;
                  node_waddr      = node_new;
                  node_wdata      = '{leaf: 1'b1, sym: in_if.data, left: '0, right: '0};
                  stack_we        = 1'b1;
                  stack_waddr     = stack_count_r[SIDX_W-1:0];
                  stack_wdata     = node_new;
                  stack_count_nxt = stack_count_r + SCNT_W'(1);
                  node_count_nxt  = node_count_r + NCNT_W'(1);
                  tree_ready_nxt  = 1'b1;
                  root_idx_nxt    = node_new;
                  root_rec_nxt    = node_wdata;
                  walk_idx_nxt    = node_new;
                  walk_rec_nxt    = node_wdata;
                end
              end else if (in_if.data == LEAF_TOKEN) begin
                expect_leaf_nxt = 1'b1;
              end else if (stack_short || node_full) begin
                state_nxt = S_ERR;
              end else begin
                // join: fetch the right operand first
                stack_re    = 1'b1;
                stack_raddr = sc_m1[SIDX_W-1:0];
                state_nxt   = S_J_LEFT;
              end
            end
            OP_DATA: begin
              if (!tree_ready_r) begin
                state_nxt = S_ERR;
              end else begin
                data_nxt    = in_if.data;
                cur_idx_nxt = walk_idx_r;
                cur_rec_nxt = walk_rec_r;
                bit_nxt     = BIT_TOP;
                node_re     = 1'b1;
                node_raddr  = in_if.data[BIT_TOP] ? walk_rec_r.right : walk_rec_r.left;
                state_nxt   = S_WALK;
              end
            end
            default: begin
              // unused code: no effect
            end
          endcase
        end
      end

      S_ERR: begin
        if (stat.out_free) begin
          cmd.single = 1'b1;
          cmd.sym    = '0;
          cmd.done   = done_now;
          cmd.err    = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_J_LEFT: begin
        r_idx_nxt   = stack_rd_r;
        stack_re    = 1'b1;
        stack_raddr = sc_m2[SIDX_W-1:0];
        state_nxt   = S_J_SYMR;
      end

      S_J_SYMR: begin
        l_idx_nxt  = stack_rd_r;
        node_re    = 1'b1;
        node_raddr = r_idx_r;
        state_nxt  = S_J_SYML;
      end

      S_J_SYML: begin
        sr_nxt     = node_rd_r.sym;
        node_re    = 1'b1;
        node_raddr = l_idx_r;
        state_nxt  = S_J_WRITE;
      end

      S_J_WRITE: begin
        // two pops and one push
        node_we         = 1'b1;
        node_waddr      = node_new;
        node_wdata      = join_rec;
        stack_we        = 1'b1;
        stack_waddr     = sc_m2[SIDX_W-1:0];
        stack_wdata     = node_new;
        stack_count_nxt = sc_m1;
        node_count_nxt  = node_count_r + NCNT_W'(1);
        tree_ready_nxt  = 1'b1;
        root_idx_nxt    = node_new;
        root_rec_nxt    = join_rec;
        walk_idx_nxt    = node_new;
        walk_rec_nxt    = join_rec;
        state_nxt       = S_IDLE;
      end

      S_WALK: begin
        if (done_now) begin
          // remaining bits are dropped
          walk_idx_nxt = cur_idx_r;
          walk_rec_nxt = cur_rec_r;
          state_nxt    = S_FLUSH;
        end else if (!w_emit || emit_ok) begin
          if (w_emit) begin
            cmd.emit    = 1'b1;
            cmd.sym     = w_sym;
            cmd.done    = done_after;
            emitted_nxt = emitted_inc;
          end
          cur_idx_nxt = w_cur_idx;
          cur_rec_nxt = w_cur_rec;
          if (bit_r == '0) begin
            walk_idx_nxt = w_cur_idx;
            walk_rec_nxt = w_cur_rec;
            state_nxt    = S_FLUSH;
          end else begin
            bit_nxt    = bit_dec;
            node_re    = 1'b1;
            node_raddr = data_r[bit_dec] ? w_cur_rec.right : w_cur_rec.left;
          end
        end
      end

      S_FLUSH: begin
        if (emit_ok) begin
          cmd.flush = stat.pend_valid;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      stack_count_r <= '0;
      node_count_r  <= '0;
      expect_leaf_r <= 1'b0;
      tree_ready_r  <= 1'b0;
      emitted_r     <= '0;
      orig_size_r   <= '0;
      root_idx_r    <= '0;
      walk_idx_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      stack_count_r <= stack_count_nxt;
      node_count_r  <= node_count_nxt;
      expect_leaf_r <= expect_leaf_nxt;
      tree_ready_r  <= tree_ready_nxt;
      emitted_r     <= emitted_nxt;
      root_idx_r    <= root_idx_nxt;
      walk_idx_r    <= walk_idx_nxt;
      if (cfg_if.valid) begin
        orig_size_r <= cfg_if.original_size;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    root_rec_r <= root_rec_nxt;
    walk_rec_r <= walk_rec_nxt;
    cur_idx_r  <= cur_idx_nxt;
    cur_rec_r  <= cur_rec_nxt;
    data_r     <= data_nxt;
    bit_r      <= bit_nxt;
    r_idx_r    <= r_idx_nxt;
    l_idx_r    <= l_idx_nxt;
    sr_r       <= sr_nxt;
  end

  // node table
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_r <= node_mem[node_raddr];
    end
  end

  // build stack
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rd_r <= stack_mem[stack_raddr];
    end
  end

  hufd_result_buf u_result_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

// ===== verif/hufd_decode_checker.sv =====
// checker for the huffman tree decoder: predicts decoded symbols and compares results
`timescale 1ns / 100ps

module hufd_decode_checker import hufd_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hufd_in_if   in_mon,
  hufd_out_if  out_mon,
  hufd_cfg_if  cfg_mon,
  output int   mismatches,
  output int   outstanding
);

  typedef logic [8:0] node_idx_t;

  typedef struct packed {
    sym_t symbol;
    logic last_in_run;
    logic stream_done;
    logic error;
  } sym_result_t;

  // tree under construction and walk position
  logic      nd_leaf  [MAX_NODES];
  sym_t      nd_sym   [MAX_NODES];
  node_idx_t nd_left  [MAX_NODES];
  node_idx_t nd_right [MAX_NODES];
  node_idx_t stk      [STACK_DEPTH];
  logic [8:0] stk_count;
  logic [9:0] nd_count;
  logic       leaf_next;
  node_idx_t  root_idx;
  node_idx_t  walk_idx;
  logic       have_tree;
  size_t      emitted;
  size_t      size_cfg;

  sym_result_t expected_syms[$];
  int          fail_total = 0;

  function automatic void clear_stream();
    stk_count = '0;
    nd_count  = '0;
    leaf_next = 1'b0;
    root_idx  = '0;
    walk_idx  = '0;
    have_tree = 1'b0;
    emitted   = '0;
  endfunction

  function automatic logic size_reached();
    return emitted >= size_cfg;
  endfunction

  function automatic sym_result_t make_result(sym_t sym, logic last, logic done, logic err);
    sym_result_t res;
    res.symbol      = sym;
    res.last_in_run = last;
    res.stream_done = done;
    res.error       = err;
    return res;
  endfunction

  // append one expected result at the tail
  function automatic void queue_expected(sym_result_t res);
    expected_syms.insert(expected_syms.size(), res);
  endfunction

  function automatic void push_error();
    queue_expected(make_result('0, 1'b1, size_reached(), 1'b1));
  endfunction

  function automatic void push_node(logic leaf, sym_t sym, node_idx_t l, node_idx_t r);
    node_idx_t n;
    n = nd_count[8:0];
    nd_leaf[n]     = leaf;
    nd_sym[n]      = sym;
    nd_left[n]     = l;
    nd_right[n]    = r;
    nd_count       = nd_count + 1'b1;
    stk[stk_count] = n;
    stk_count      = stk_count + 1'b1;
  endfunction

  // every tree change moves the root to the stack top and restarts the walk
  function automatic void retarget_root();
    have_tree = (stk_count != 0);
    if (stk_count != 0)
      root_idx = stk[stk_count - 1];
    walk_idx = root_idx;
  endfunction

  // expected results of one input transaction
  function automatic void decode_transaction(op_t op, sym_t data);
    node_idx_t l;
    node_idx_t r;
    node_idx_t cur;
    sym_t      sym;
    int        produced;
    int        b;
    produced = 0;
    case (op)
      OP_START: clear_stream();
      OP_TREE: begin
        if (leaf_next) begin
          leaf_next = 1'b0;
          if (nd_count >= MAX_NODES || stk_count >= STACK_DEPTH) begin
            push_error();
          end else begin
            push_node(1'b1, data, '0, '0);
            retarget_root();
          end
        end else if (data == LEAF_TOKEN) begin
          leaf_next = 1'b1;
        end else if (stk_count < 2 || nd_count >= MAX_NODES) begin
          push_error();
        end else begin
          // smaller first byte goes left, ties put the top entry left
          r = stk[stk_count - 1];
          l = stk[stk_count - 2];
          stk_count = stk_count - 2'd2;
          if (nd_sym[l] < nd_sym[r])
            push_node(1'b0, nd_sym[l], l, r);
          else
            push_node(1'b0, nd_sym[r], r, l);
          retarget_root();
        end
      end
      OP_DATA: begin
        if (!have_tree) begin
          push_error();
        end else begin
          cur = walk_idx;
          for (b = BIT_TOP; b >= 0; b--) begin
            if (size_reached())
              break;
            if (nd_leaf[root_idx]) begin
              // lone leaf: one symbol per code bit
              sym = nd_sym[root_idx];
              cur = root_idx;
            end else begin
              cur = data[b] ? nd_right[cur] : nd_left[cur];
              if (!nd_leaf[cur])
                continue;
              sym = nd_sym[cur];
              cur = root_idx;
            end
            emitted = emitted + 1'b1;
            queue_expected(make_result(sym, 1'b0, size_reached(), 1'b0));
            produced++;
          end
          walk_idx = cur;
          if (produced > 0)
            expected_syms[expected_syms.size() - 1].last_in_run = 1'b1;
        end
      end
      // reserved op code is ignored
      default: ;
    endcase
  endfunction

  function automatic void check_result();
    sym_result_t want;
    if (expected_syms.size() == 0) begin
      $error("unexpected result: symbol %0h last %0b done %0b error %0b", out_mon.symbol,
             out_mon.last_in_run, out_mon.stream_done, out_mon.error);
      fail_total++;
    end else begin
      want = expected_syms.pop_front();
      if (out_mon.symbol !== want.symbol) begin
        $error("symbol: expected %0h, actual %0h", want.symbol, out_mon.symbol);
        fail_total++;
      end
      if (out_mon.last_in_run !== want.last_in_run) begin
        $error("last_in_run: expected %0b, actual %0b", want.last_in_run,
               out_mon.last_in_run);
        fail_total++;
      end
      if (out_mon.stream_done !== want.stream_done) begin
        $error("stream_done: expected %0b, actual %0b", want.stream_done,
               out_mon.stream_done);
        fail_total++;
      end
      if (out_mon.error !== want.error) begin
        $error("error: expected %0b, actual %0b", want.error, out_mon.error);
        fail_total++;
      end
    end
  endfunction

  // watch the three channels at each clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream();
      size_cfg = '0;
      expected_syms.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        size_cfg = cfg_mon.original_size;
      if (in_mon.valid && in_mon.ready)
        decode_transaction(in_mon.op, in_mon.data);
      if (out_mon.valid && out_mon.ready)
        check_result();
    end
    mismatches  <= fail_total;
    outstanding <= expected_syms.size();
  end

endmodule

// ===== verif/huffman_tree_decoder_unit_test.sv =====
// testbench top for the huffman tree decoder: stimulus, idling and verdict
`timescale 1ns / 100ps

module huffman_tree_decoder_unit_test;
  import hufd_pkg::*;

  localparam op_t OP_NONE      = 2'd3;
  localparam int  RANDOM_ITEMS = 350;
  localparam int  QUIET_CYCLES = 20;
  localparam int  CYCLE_LIMIT  = 500000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   cycle_count    = 0;
  int   send_idle_pct  = 11;
  int   recv_stall_pct = 54;
  int   random_items   = 0;
  bit   count_items    = 1'b0;

  hufd_in_if  in_if ();
  hufd_out_if out_if ();
  hufd_cfg_if cfg_if ();

  huffman_tree_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  hufd_decode_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_mon     (cfg_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result-side backpressure
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(op_t op, sym_t data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.data  <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (count_items && op != OP_NONE)
      random_items++;
  endtask

  task automatic send_leaf(sym_t sym);
    send_item(OP_TREE, LEAF_TOKEN);
    send_item(OP_TREE, sym);
  endtask

  // any token but the leaf marker joins
  function automatic sym_t join_token();
    sym_t t;
    t = sym_t'($urandom_range(0, 254));
    if (t >= LEAF_TOKEN)
      t = t + 1'b1;
    return t;
  endfunction

  // wait for all results, then for the block to settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(size_t value);
    drain();
    cfg_if.valid         <= 1'b1;
    cfg_if.original_size <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_noise(int count);
    repeat (count) send_item(op_t'($urandom_range(0, 3)), sym_t'($urandom_range(0, 255)));
  endtask

  // random postorder tree; an incomplete one may leave several stack entries
  task automatic send_tree(int leaves, bit complete);
    int depth;
    depth = 0;
    while (leaves > 0 || (complete && depth > 1)) begin
      if (leaves > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        send_leaf(sym_t'($urandom_range(0, 255)));
        leaves--;
        depth++;
      end else begin
        send_item(OP_TREE, join_token());
        depth--;
      end
    end
  endtask

  // one stream: size, start, tree, code bytes, with some broken variants
  task automatic run_random_stream();
    size_t size_pick;
    int    kind;
    case ($urandom_range(0, 9))
      0:       size_pick = '0;
      1:       size_pick = '1;
      2:       size_pick = $urandom();
      default: size_pick = $urandom_range(1, 40);
    endcase
    kind = $urandom_range(0, 9);
    if (random_items < RANDOM_ITEMS / 3) begin
      send_idle_pct  = 11;
      recv_stall_pct = 54;
    end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct  = 54;
      recv_stall_pct = 11;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    write_size(size_pick);
    send_item(OP_START, sym_t'($urandom_range(0, 255)));
    if (kind == 0)
      send_noise($urandom_range(3, 10));
    send_tree($urandom_range(1, 12), kind != 1);
    if (kind == 2)
      send_noise($urandom_range(1, 4));
    repeat ($urandom_range(1, 12)) send_item(OP_DATA, sym_t'($urandom_range(0, 255)));
  endtask

  // stimulus and verdict
  initial begin
    in_if.valid          <= 1'b0;
    in_if.op             <= OP_TREE;
    in_if.data           <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.original_size <= '0;
    rst_n                <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: errors before any tree, reserved op
    send_item(OP_DATA, 8'hFF);
    send_item(OP_TREE, 8'h00);
    send_item(OP_NONE, 8'hFF);
    write_size('1);
    send_item(OP_START, 8'h00);
    // single leaf emits once per bit
    send_leaf(8'hFF);
    send_item(OP_DATA, 8'hA5);
    // join with one entry underflows
    send_item(OP_TREE, 8'hFF);
    send_leaf(8'h00);
    send_item(OP_TREE, 8'hFE);
    send_item(OP_DATA, 8'h5A);
    // equal first bytes on a join
    send_leaf(8'h00);
    send_item(OP_TREE, 8'h02);
    send_item(OP_DATA, 8'hC3);
    send_item(OP_DATA, 8'h3C);
    // size reached inside a byte, later bits dropped
    write_size(32'd3);
    send_item(OP_START, 8'hFF);
    send_leaf(8'h61);
    send_leaf(8'h62);
    send_item(OP_TREE, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h00);
    send_item(OP_TREE, 8'h00);

    // stack overflow on a leaf
    write_size('1);
    send_item(OP_START, 8'h00);
    repeat (STACK_DEPTH_DEF + 1) send_leaf(sym_t'($urandom_range(0, 255)));
    send_item(OP_DATA, sym_t'($urandom_range(0, 255)));
    // node table overflow on a leaf and on a join
    send_item(OP_START, 8'h00);
    send_leaf(sym_t'($urandom_range(0, 255)));
    repeat (MAX_NODES_DEF / 2 - 1) begin
      send_leaf(sym_t'($urandom_range(0, 255)));
      send_item(OP_TREE, join_token());
    end
    send_leaf(sym_t'($urandom_range(0, 255)));
    send_leaf(sym_t'($urandom_range(0, 255)));
    send_item(OP_TREE, join_token());
    send_item(OP_DATA, sym_t'($urandom_range(0, 255)));

    // random streams
    count_items = 1'b1;
    while (random_items < RANDOM_ITEMS) run_random_stream();

    drain();
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== huffman_tree_decoder_unit.f =====
hw/rtl/hufd_pkg.sv
hw/rtl/hufd_in_if.sv
hw/rtl/hufd_out_if.sv
hw/rtl/hufd_cfg_if.sv
hw/rtl/hufd_result_buf.sv
hw/rtl/huffman_tree_decoder_unit.sv
verif/hufd_decode_checker.sv
verif/huffman_tree_decoder_unit_test.sv
